[rtl/core/ffca_pkg.sv]
// Shared types and codes of the first-fit coalescing allocator.
`timescale 1ns / 1ps
`default_nettype none
package ffca_pkg;

	localparam int ADDR_W = 48;
	localparam int LEN_W  = 40;

	typedef struct packed {
		logic [ADDR_W-1:0] start;
		logic [LEN_W-1:0]  len;
	} chunk_t;

	typedef enum logic [1:0] {
		CMD_ALLOC = 2'd0,
		CMD_FREE  = 2'd1,
		CMD_FIND  = 2'd2,
		CMD_NONE  = 2'd3
	} cmd_e;

	typedef enum logic [2:0] {
		ST_OK      = 3'd0,
		ST_NOFIT   = 3'd1,
		ST_UNKNOWN = 3'd2,
		ST_OVERLAP = 3'd3,
		ST_NOTCOV  = 3'd4,
		ST_TFULL   = 3'd5
	} status_e;

	typedef enum logic {
		CFG_POOL_BASE   = 1'b0,
		CFG_POOL_LENGTH = 1'b1
	} cfg_e;

endpackage
`default_nettype wire

[rtl/core/ffca_chunk_ram.sv]
// Chunk table memory: one write port, one registered read port.
`timescale 1ns / 1ps
`default_nettype none
module ffca_chunk_ram #(
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire ffca_pkg::chunk_t         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output ffca_pkg::chunk_t              rdata
);

	ffca_pkg::chunk_t mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

[rtl/core/first_fit_coalescing_allocator.sv]
// Top level: first-fit pool allocator with coalescing free table and its sequencer.
`timescale 1ns / 1ps
`default_nettype none
// Manages one memory pool as an address-sorted table of free chunks and an
// unordered table of live allocations, both in memories with one write port
// and one registered read port. One request is handled at a time; s_tready is
// high only while the sequencer is idle, and a finished result waits in the
// output register so the next request can be taken meanwhile. An allocate
// scans the free chunks and shifts entries when a chunk is split or used up
// whole; a free scans the allocations, scans the free chunks, shifts entries
// when needed and compacts the allocation table; a lookup scans the
// allocations.
// Writing either configuration register re-initializes the pool to a single
// free chunk (length clipped to end at or below 2^48) and empties the
// allocation table; write it only while idle. No clearing pass is needed.
module first_fit_coalescing_allocator #(
	parameter int FREE_ENTRIES  = 64,
	parameter int ALLOC_ENTRIES = 64
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	// request channel
	input  wire logic         s_tvalid,
	output logic              s_tready,
	input  wire logic [95:0]  s_tdata,   // address[47:0], size[87:48], align_log2[93:88], zero
	input  wire logic [1:0]   s_tuser,   // command[1:0]
	// result channel
	output logic              m_tvalid,
	input  wire logic         m_tready,
	output logic [127:0]      m_tdata,   // result_address[47:0], freed_size[87:48],
	                                     // bytes_remaining[127:88]
	output logic [2:0]        m_tuser,   // status[2:0]
	// configuration
	input  wire logic         cfg_we,
	input  wire logic         cfg_addr,
	input  wire logic [47:0]  cfg_wdata
);

	localparam int FAW = $clog2(FREE_ENTRIES);
	localparam int FCW = $clog2(FREE_ENTRIES + 1);
	localparam int AAW = $clog2(ALLOC_ENTRIES);
	localparam int ACW = $clog2(ALLOC_ENTRIES + 1);
	localparam logic [FCW-1:0] FREE_FULL  = FCW'(FREE_ENTRIES);
	localparam logic [ACW-1:0] ALLOC_FULL = ACW'(ALLOC_ENTRIES);

	typedef enum logic [18:0] {
		S_IDLE = 19'h00001,
		S_ARD  = 19'h00002,
		S_ARND = 19'h00004,
		S_AFIT = 19'h00008,
		S_ADEC = 19'h00010,
		S_UPRD = 19'h00020,
		S_UPWR = 19'h00040,
		S_DNRD = 19'h00080,
		S_DNWR = 19'h00100,
		S_FRD  = 19'h00200,
		S_FCHK = 19'h00400,
		S_PRD  = 19'h00800,
		S_PCHK = 19'h01000,
		S_FDEC = 19'h02000,
		S_MVRD = 19'h04000,
		S_MVWR = 19'h08000,
		S_LRD  = 19'h10000,
		S_LCHK = 19'h20000,
		S_DONE = 19'h40000
	} state_t;

	state_t             state_q;
	ffca_pkg::cmd_e     cmd_q;
	logic [47:0]        addr_q;
	logic [39:0]        size_q;
	logic [5:0]         align_q;
	logic [48:0]        aend_q;      // addr + size
	logic [FCW-1:0]     idx_q;       // free scan index (chunk i / position p)
	logic [FCW-1:0]     k_q;         // shift cursor
	logic [FCW-1:0]     pos_q;       // insert position
	ffca_pkg::chunk_t   ins_q;       // chunk to insert
	logic [47:0]        s_q;
	logic [48:0]        t_q;
	logic [48:0]        e_q;
	logic [48:0]        tend_q;
	logic               big_q;       // alignment beyond the address space
	logic [ACW-1:0]     j_q;
	ffca_pkg::chunk_t   pv_q;        // free chunk below the freed range
	logic [48:0]        pend_q;
	ffca_pkg::chunk_t   cur_q;       // free chunk at or above the freed range
	ffca_pkg::status_e  st_q;
	logic [47:0]        res_q;
	logic [39:0]        freed_q;
	logic [FCW-1:0]     free_count_q;
	logic [ACW-1:0]     alloc_count_q;
	logic [39:0]        free_bytes_q;
	logic [47:0]        base_q;
	logic [39:0]        plen_q;
	logic [39:0]        clip_q;
	logic               e0_q;        // entry zero of the free memory is live
	logic               rd0_init_q;  // last free read hit the init chunk
	logic               m_tvalid_q;
	logic [127:0]       m_tdata_q;
	logic [2:0]         m_tuser_q;

	// memories
	logic               free_we, alloc_we;
	logic [FCW-1:0]     free_waddr_c, free_raddr_c;
	logic [ACW-1:0]     alloc_waddr_c, alloc_raddr_c;
	ffca_pkg::chunk_t   free_wdata, alloc_wdata, free_rdata, free_rd, alloc_rd;

	ffca_chunk_ram #(.DEPTH(FREE_ENTRIES)) u_free (
		.clk   (clk),
		.we    (free_we),
		.waddr (free_waddr_c[FAW-1:0]),
		.wdata (free_wdata),
		.raddr (free_raddr_c[FAW-1:0]),
		.rdata (free_rdata)
	);

	ffca_chunk_ram #(.DEPTH(ALLOC_ENTRIES)) u_alloc (
		.clk   (clk),
		.we    (alloc_we),
		.waddr (alloc_waddr_c[AAW-1:0]),
		.wdata (alloc_wdata),
		.raddr (alloc_raddr_c[AAW-1:0]),
		.rdata (alloc_rd)
	);

	// until the datapath writes entry zero, it is the init chunk from the registers
	always_comb begin
		free_rd = free_rdata;
		if (rd0_init_q) begin
			free_rd.start = base_q;
			free_rd.len   = clip_q;
		end
	end

	// request fields
	logic [47:0] in_addr;
	logic [39:0] in_size;
	logic [5:0]  in_align;
	assign in_addr  = s_tdata[47:0];
	assign in_size  = s_tdata[87:48];
	assign in_align = s_tdata[93:88];

	// pool init values with the incoming write folded in
	logic [47:0] base_n;
	logic [39:0] plen_n, clip_n;
	logic [48:0] room_c;
	always_comb begin
		base_n = base_q;
		plen_n = plen_q;
		unique case (ffca_pkg::cfg_e'(cfg_addr))
			ffca_pkg::CFG_POOL_BASE:   base_n = cfg_wdata;
			ffca_pkg::CFG_POOL_LENGTH: plen_n = cfg_wdata[39:0];
		endcase
		room_c = 49'h1_0000_0000_0000 - {1'b0, base_n};
		clip_n = ({9'd0, plen_n} > room_c) ? room_c[39:0] : plen_n;
	end

	// alignment round-up of the chunk start
	logic [48:0] mask_c, t_c;
	assign mask_c = (49'd1 << align_q) - 49'd1;
	assign t_c    = (align_q >= 6'd48) ? 49'd0
	              : (({1'b0, free_rd.start} + mask_c) & ~mask_c);

	// fit test
	logic [48:0] tend_c;
	logic        fit_c;
	assign tend_c = t_q + {9'd0, size_q};
	assign fit_c  = !big_q && (tend_c <= e_q);

	// split decision
	logic [48:0] pad_c, tail_c;
	logic        pad_nz, tail_nz, adec_full;
	assign pad_c     = t_q - {1'b0, s_q};
	assign tail_c    = e_q - tend_q;
	assign pad_nz    = pad_c != 49'd0;
	assign tail_nz   = tail_c != 49'd0;
	assign adec_full = (alloc_count_q == ALLOC_FULL)
	                || (pad_nz && tail_nz && free_count_q == FREE_FULL);

	// merge decision
	logic have_prev, have_cur, f_ov, f_pm, f_nm, f_full;
	assign have_prev = idx_q != '0;
	assign have_cur  = idx_q != free_count_q;
	assign f_ov   = (have_cur && {1'b0, cur_q.start} < aend_q)
	             || (have_prev && pend_q > {1'b0, addr_q});
	assign f_pm   = have_prev && pend_q == {1'b0, addr_q};
	assign f_nm   = have_cur && {1'b0, cur_q.start} == aend_q;
	assign f_full = !f_pm && !f_nm && free_count_q == FREE_FULL;

	// lookup match
	logic [48:0] lend_c;
	logic        lmatch_c;
	assign lend_c   = {1'b0, alloc_rd.start} + {9'd0, alloc_rd.len};
	assign lmatch_c = (alloc_rd.start == addr_q && alloc_rd.len >= size_q)
	               || (alloc_rd.start < addr_q && lend_c >= aend_q);

	// memory addresses and writes
	always_comb begin
		free_raddr_c  = idx_q;
		alloc_raddr_c = j_q;
		free_we       = 1'b0;
		free_waddr_c  = idx_q;
		free_wdata    = free_rd;
		alloc_we      = 1'b0;
		alloc_waddr_c = alloc_count_q;
		alloc_wdata   = alloc_rd;
		unique case (state_q)
			S_UPRD: begin
				free_raddr_c = k_q - FCW'(1);
				if (k_q == pos_q) begin
					free_we      = 1'b1;
					free_waddr_c = pos_q;
					free_wdata   = ins_q;
				end
			end
			S_UPWR: begin
				free_we      = 1'b1;
				free_waddr_c = k_q;
			end
			S_DNRD: free_raddr_c = k_q + FCW'(1);
			S_DNWR: begin
				free_we      = 1'b1;
				free_waddr_c = k_q;
			end
			S_ADEC: begin
				if (!adec_full) begin
					alloc_we          = 1'b1;
					alloc_wdata.start = t_q[47:0];
					alloc_wdata.len   = size_q;
					if (pad_nz) begin
						free_we          = 1'b1;
						free_wdata.start = s_q;
						free_wdata.len   = pad_c[39:0];
					end else if (tail_nz) begin
						free_we          = 1'b1;
						free_wdata.start = tend_q[47:0];
						free_wdata.len   = tail_c[39:0];
					end
				end
			end
			S_FDEC: begin
				if (!f_ov && !f_full) begin
					if (f_pm) begin
						free_we          = 1'b1;
						free_waddr_c     = idx_q - FCW'(1);
						free_wdata.start = pv_q.start;
						free_wdata.len   = pv_q.len + size_q + (f_nm ? cur_q.len : 40'd0);
					end else if (f_nm) begin
						free_we          = 1'b1;
						free_wdata.start = addr_q;
						free_wdata.len   = cur_q.len + size_q;
					end
				end
			end
			S_MVRD: alloc_raddr_c = alloc_count_q - ACW'(1);
			S_MVWR: begin
				alloc_we      = 1'b1;
				alloc_waddr_c = j_q;
			end
			default: ;
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			cmd_q         <= ffca_pkg::CMD_NONE;
			addr_q        <= '0;
			size_q        <= '0;
			align_q       <= '0;
			aend_q        <= '0;
			idx_q         <= '0;
			k_q           <= '0;
			pos_q         <= '0;
			ins_q         <= '0;
			s_q           <= '0;
			t_q           <= '0;
			e_q           <= '0;
			tend_q        <= '0;
			big_q         <= 1'b0;
			j_q           <= '0;
			pv_q          <= '0;
			pend_q        <= '0;
			cur_q         <= '0;
			st_q          <= ffca_pkg::ST_OK;
			res_q         <= '0;
			freed_q       <= '0;
			free_count_q  <= FCW'(1);
			alloc_count_q <= '0;
			free_bytes_q  <= '0;
			base_q        <= '0;
			plen_q        <= '0;
			clip_q        <= '0;
			e0_q          <= 1'b0;
			rd0_init_q    <= 1'b0;
			m_tvalid_q    <= 1'b0;
			m_tdata_q     <= '0;
			m_tuser_q     <= '0;
		end else begin
			rd0_init_q <= (free_raddr_c[FAW-1:0] == '0) && !e0_q;
			if (free_we && free_waddr_c[FAW-1:0] == '0) begin
				e0_q <= 1'b1;
			end
			if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						cmd_q   <= ffca_pkg::cmd_e'(s_tuser);
						addr_q  <= in_addr;
						size_q  <= in_size;
						align_q <= in_align;
						aend_q  <= {1'b0, in_addr} + {9'd0, in_size};
						st_q    <= ffca_pkg::ST_OK;
						res_q   <= '0;
						freed_q <= '0;
						idx_q   <= '0;
						j_q     <= '0;
						unique case (ffca_pkg::cmd_e'(s_tuser))
							ffca_pkg::CMD_ALLOC: begin
								if (in_size == '0) begin
									st_q    <= ffca_pkg::ST_NOFIT;
									state_q <= S_DONE;
								end else begin
									state_q <= S_ARD;
								end
							end
							ffca_pkg::CMD_FREE: state_q <= S_FRD;
							ffca_pkg::CMD_FIND: state_q <= S_LRD;
							ffca_pkg::CMD_NONE: state_q <= S_DONE;
						endcase
					end
				end
				// allocate: first-fit scan
				S_ARD: begin
					if (idx_q == free_count_q) begin
						st_q    <= ffca_pkg::ST_NOFIT;
						state_q <= S_DONE;
					end else begin
						state_q <= S_ARND;
					end
				end
				S_ARND: begin
					s_q     <= free_rd.start;
					e_q     <= {1'b0, free_rd.start} + {9'd0, free_rd.len};
					t_q     <= t_c;
					big_q   <= (align_q >= 6'd48) && (free_rd.start != '0);
					state_q <= S_AFIT;
				end
				S_AFIT: begin
					if (fit_c) begin
						tend_q  <= tend_c;
						state_q <= S_ADEC;
					end else begin
						idx_q   <= idx_q + FCW'(1);
						state_q <= S_ARD;
					end
				end
				S_ADEC: begin
					if (adec_full) begin
						st_q    <= ffca_pkg::ST_TFULL;
						state_q <= S_DONE;
					end else begin
						res_q         <= t_q[47:0];
						alloc_count_q <= alloc_count_q + ACW'(1);
						free_bytes_q  <= free_bytes_q - size_q;
						if (pad_nz && tail_nz) begin
							pos_q       <= idx_q + FCW'(1);
							k_q         <= free_count_q;
							ins_q.start <= tend_q[47:0];
							ins_q.len   <= tail_c[39:0];
							state_q     <= S_UPRD;
						end else if (pad_nz || tail_nz) begin
							state_q <= S_DONE;
						end else begin
							k_q     <= idx_q;
							state_q <= S_DNRD;
						end
					end
				end
				// open a hole at pos_q
				S_UPRD: begin
					if (k_q == pos_q) begin
						free_count_q <= free_count_q + FCW'(1);
						state_q      <= (cmd_q == ffca_pkg::CMD_FREE) ? S_MVRD : S_DONE;
					end else begin
						state_q <= S_UPWR;
					end
				end
				S_UPWR: begin
					k_q     <= k_q - FCW'(1);
					state_q <= S_UPRD;
				end
				// close the hole at k_q
				S_DNRD: begin
					if (k_q + FCW'(1) >= free_count_q) begin
						free_count_q <= free_count_q - FCW'(1);
						state_q      <= (cmd_q == ffca_pkg::CMD_FREE) ? S_MVRD : S_DONE;
					end else begin
						state_q <= S_DNWR;
					end
				end
				S_DNWR: begin
					k_q     <= k_q + FCW'(1);
					state_q <= S_DNRD;
				end
				// free: find the allocation, then its place among free chunks
				S_FRD: begin
					if (j_q == alloc_count_q) begin
						st_q    <= ffca_pkg::ST_UNKNOWN;
						state_q <= S_DONE;
					end else begin
						state_q <= S_FCHK;
					end
				end
				S_FCHK: begin
					if (alloc_rd.start == addr_q) begin
						size_q  <= alloc_rd.len;
						aend_q  <= {1'b0, addr_q} + {9'd0, alloc_rd.len};
						state_q <= S_PRD;
					end else begin
						j_q     <= j_q + ACW'(1);
						state_q <= S_FRD;
					end
				end
				S_PRD: begin
					state_q <= (idx_q == free_count_q) ? S_FDEC : S_PCHK;
				end
				S_PCHK: begin
					if (free_rd.start < addr_q) begin
						pv_q    <= free_rd;
						pend_q  <= {1'b0, free_rd.start} + {9'd0, free_rd.len};
						idx_q   <= idx_q + FCW'(1);
						state_q <= S_PRD;
					end else begin
						cur_q   <= free_rd;
						state_q <= S_FDEC;
					end
				end
				S_FDEC: begin
					if (f_ov) begin
						st_q    <= ffca_pkg::ST_OVERLAP;
						state_q <= S_DONE;
					end else if (f_full) begin
						st_q    <= ffca_pkg::ST_TFULL;
						state_q <= S_DONE;
					end else begin
						free_bytes_q <= free_bytes_q + size_q;
						freed_q      <= size_q;
						if (f_pm && f_nm) begin
							k_q     <= idx_q;
							state_q <= S_DNRD;
						end else if (f_pm || f_nm) begin
							state_q <= S_MVRD;
						end else begin
							pos_q       <= idx_q;
							k_q         <= free_count_q;
							ins_q.start <= addr_q;
							ins_q.len   <= size_q;
							state_q     <= S_UPRD;
						end
					end
				end
				// last allocation moves into the freed slot
				S_MVRD: state_q <= S_MVWR;
				S_MVWR: begin
					alloc_count_q <= alloc_count_q - ACW'(1);
					state_q       <= S_DONE;
				end
				// lookup
				S_LRD: begin
					if (j_q == alloc_count_q) begin
						st_q    <= ffca_pkg::ST_NOTCOV;
						state_q <= S_DONE;
					end else begin
						state_q <= S_LCHK;
					end
				end
				S_LCHK: begin
					if (lmatch_c) begin
						res_q   <= alloc_rd.start;
						state_q <= S_DONE;
					end else begin
						j_q     <= j_q + ACW'(1);
						state_q <= S_LRD;
					end
				end
				S_DONE: begin
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						m_tuser_q  <= st_q;
						m_tdata_q  <= {free_bytes_q, freed_q, res_q};
						state_q    <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase

			// pool re-init (the user writes it only while idle; the block does not enforce this)
			if (cfg_we) begin
				base_q        <= base_n;
				plen_q        <= plen_n;
				clip_q        <= clip_n;
				free_count_q  <= FCW'(1);
				alloc_count_q <= '0;
				free_bytes_q  <= clip_n;
				e0_q          <= 1'b0;
			end
		end
	end

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

endmodule
`default_nettype wire

[dv/first_fit_coalescing_allocator_tb.sv]
// Testbench for the first-fit coalescing allocator: self-checking stream test.
`timescale 1ns / 1ps
module first_fit_coalescing_allocator_tb;

	localparam int FREE_N      = 64;
	localparam int ALLOC_N     = 64;
	localparam int IDLE_LIMIT  = 8000;  // covers the worst request plus the long hold-off
	localparam int HOLD_CYCLES = 400;

	typedef struct {
		ffca_pkg::cmd_e cmd;
		logic [47:0]    addr;
		logic [39:0]    size;
		logic [5:0]     align;
	} request_t;

	typedef struct {
		logic [2:0]  status;
		logic [47:0] addr;
		logic [39:0] freed;
		logic [39:0] remaining;
	} outcome_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [95:0]  s_tdata = '0;
	logic [1:0]   s_tuser = '0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [127:0] m_tdata;
	logic [2:0]   m_tuser;
	logic         cfg_we = 1'b0;
	logic         cfg_addr = 1'b0;
	logic [47:0]  cfg_wdata = '0;

	first_fit_coalescing_allocator #(.FREE_ENTRIES(FREE_N), .ALLOC_ENTRIES(ALLOC_N)) dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// pool mirror: sorted free chunks, unordered live allocations
	bit [63:0] pool_base, pool_len;
	bit [63:0] hole_start [FREE_N];
	bit [63:0] hole_len   [FREE_N];
	int        hole_cnt;
	bit [63:0] live_start [ALLOC_N];
	bit [63:0] live_len   [ALLOC_N];
	int        live_cnt;
	bit [63:0] bytes_free;

	request_t pending_requests[$];
	outcome_t expected_outcomes[$];
	int  send_idle_pct = 0, recv_stall_pct = 0;
	bit  hold_req = 1'b0;
	bit  in_taken = 1'b0;
	int  errors = 0, n_requests = 0, n_results = 0;
	int  status_seen [6];

	function automatic void pool_reinit();
		bit [63:0] room;
		room = 64'h1_0000_0000_0000 - pool_base;
		hole_start[0] = pool_base;
		hole_len[0]   = (pool_len > room) ? room : pool_len;
		hole_cnt      = 1;
		live_cnt      = 0;
		bytes_free    = hole_len[0];
	endfunction

	function automatic void hole_insert(int pos, bit [63:0] s, bit [63:0] l);
		for (int k = hole_cnt; k > pos; k--) begin
			hole_start[k] = hole_start[k-1];
			hole_len[k]   = hole_len[k-1];
		end
		hole_start[pos] = s;
		hole_len[pos]   = l;
		hole_cnt++;
	endfunction

	function automatic void hole_remove(int pos);
		for (int k = pos; k + 1 < hole_cnt; k++) begin
			hole_start[k] = hole_start[k+1];
			hole_len[k]   = hole_len[k+1];
		end
		hole_cnt--;
	endfunction

	function automatic ffca_pkg::status_e carve(bit [63:0] sz, int a, output bit [63:0] at);
		bit [63:0] mask, s, e, t, pad, tail;
		int i;
		bit hit;
		mask = (64'd1 << a) - 64'd1;
		hit = 1'b0;
		at = 0;
		if (sz == 0) return ffca_pkg::ST_NOFIT;
		for (i = 0; i < hole_cnt; i++) begin
			s = hole_start[i];
			e = s + hole_len[i];
			t = (s + mask) & ~mask;
			if (t + sz <= e) begin
				hit = 1'b1;
				break;
			end
		end
		if (!hit) return ffca_pkg::ST_NOFIT;
		pad  = t - s;
		tail = e - (t + sz);
		if (live_cnt >= ALLOC_N) return ffca_pkg::ST_TFULL;
		if (pad != 0 && tail != 0 && hole_cnt >= FREE_N) return ffca_pkg::ST_TFULL;
		if (pad != 0) begin
			hole_len[i] = pad;
			if (tail != 0) hole_insert(i + 1, t + sz, tail);
		end else if (tail != 0) begin
			hole_start[i] = t + sz;
			hole_len[i]   = tail;
		end else begin
			hole_remove(i);
		end
		live_start[live_cnt] = t;
		live_len[live_cnt]   = sz;
		live_cnt++;
		bytes_free -= sz;
		at = t;
		return ffca_pkg::ST_OK;
	endfunction

	function automatic ffca_pkg::status_e release_block(bit [63:0] adr,
		output bit [63:0] freed);
		int j, p;
		bit hit, pm, nm;
		bit [63:0] sz;
		hit = 1'b0;
		p = 0;
		freed = 0;
		for (j = 0; j < live_cnt; j++)
			if (live_start[j] == adr) begin
				hit = 1'b1;
				break;
			end
		if (!hit) return ffca_pkg::ST_UNKNOWN;
		sz = live_len[j];
		while (p < hole_cnt && hole_start[p] < adr) p++;
		if (p < hole_cnt && hole_start[p] < adr + sz) return ffca_pkg::ST_OVERLAP;
		if (p > 0 && hole_start[p-1] + hole_len[p-1] > adr) return ffca_pkg::ST_OVERLAP;
		pm = p > 0 && hole_start[p-1] + hole_len[p-1] == adr;
		nm = p < hole_cnt && hole_start[p] == adr + sz;
		if (!pm && !nm && hole_cnt >= FREE_N) return ffca_pkg::ST_TFULL;
		if (pm && nm) begin
			hole_len[p-1] += sz + hole_len[p];
			hole_remove(p);
		end else if (pm) begin
			hole_len[p-1] += sz;
		end else if (nm) begin
			hole_start[p] = adr;
			hole_len[p]  += sz;
		end else begin
			hole_insert(p, adr, sz);
		end
		live_cnt--;
		live_start[j] = live_start[live_cnt];
		live_len[j]   = live_len[live_cnt];
		bytes_free += sz;
		freed = sz;
		return ffca_pkg::ST_OK;
	endfunction

	function automatic outcome_t serve(request_t r);
		outcome_t o;
		bit [63:0] at, freed, s, l;
		ffca_pkg::status_e st;
		at = 0;
		freed = 0;
		st = ffca_pkg::ST_OK;
		case (r.cmd)
			ffca_pkg::CMD_ALLOC: st = carve(64'(r.size), int'(r.align), at);
			ffca_pkg::CMD_FREE:  st = release_block(64'(r.addr), freed);
			ffca_pkg::CMD_FIND: begin
				st = ffca_pkg::ST_NOTCOV;
				for (int j = 0; j < live_cnt; j++) begin
					s = live_start[j];
					l = live_len[j];
					if ((s == r.addr && l >= r.size) ||
						(s < r.addr && s + l >= r.addr + r.size)) begin
						at = s;
						st = ffca_pkg::ST_OK;
						break;
					end
				end
			end
			default: ;
		endcase
		o.status = st;
		o.addr = at[47:0];
		o.freed = freed[39:0];
		o.remaining = bytes_free[39:0];
		return o;
	endfunction

	// monitor: check results, then predict newly taken requests
	int quiet_cycles = 0;
	always @(posedge clk) begin
		outcome_t want, got;
		request_t r;
		if (arst_n) begin
			quiet_cycles++;
			if (m_tvalid && m_tready) begin
				quiet_cycles = 0;
				n_results++;
				got.status = m_tuser;
				got.addr = m_tdata[47:0];
				got.freed = m_tdata[87:48];
				got.remaining = m_tdata[127:88];
				if (expected_outcomes.size() == 0) begin
					errors++;
					$display("%0t: result with nothing expected: %p", $time, got);
				end else begin
					want = expected_outcomes.pop_front();
					if (got.status < 6) status_seen[got.status]++;
					if (got.status != want.status)
						$display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
					if (got.addr != want.addr)
						$display("%0t: address expected %h actual %h", $time, want.addr, got.addr);
					if (got.freed != want.freed)
						$display("%0t: freed expected %h actual %h", $time, want.freed, got.freed);
					if (got.remaining != want.remaining)
						$display("%0t: remaining expected %h actual %h", $time,
							want.remaining, got.remaining);
					if (got != want) errors++;
				end
			end
			in_taken = s_tvalid && s_tready;
			if (in_taken) begin
				quiet_cycles = 0;
				n_requests++;
				r.cmd = ffca_pkg::cmd_e'(s_tuser);
				r.addr = s_tdata[47:0];
				r.size = s_tdata[87:48];
				r.align = s_tdata[93:88];
				expected_outcomes.insert(expected_outcomes.size(), serve(r));
			end
			if (quiet_cycles >= IDLE_LIMIT) begin
				$display("%0t: no handshake for %0d cycles", $time, IDLE_LIMIT);
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	// request driver
	always @(negedge clk) begin
		request_t r;
		if (arst_n && (!s_tvalid || in_taken)) begin
			if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				r = pending_requests.pop_front();
				s_tvalid <= 1'b1;
				s_tuser  <= r.cmd;
				s_tdata  <= {2'b0, r.align, r.size, r.addr};
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// result acceptor, with one long hold-off on request
	always @(negedge clk) begin
		int hold_left;
		if (arst_n) begin
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (hold_req) begin
				hold_req = 1'b0;
				hold_left = HOLD_CYCLES;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	task automatic push_req(ffca_pkg::cmd_e c, logic [47:0] a, logic [39:0] s,
		logic [5:0] al);
		request_t r;
		r.cmd = c;
		r.addr = a;
		r.size = s;
		r.align = al;
		pending_requests.insert(pending_requests.size(), r);
	endtask

	task automatic wait_drained();
		while (pending_requests.size() != 0 || expected_outcomes.size() != 0 || s_tvalid)
			@(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	task automatic set_pool(logic [47:0] base, logic [39:0] len);
		cfg_we    <= 1'b1;
		cfg_addr  <= ffca_pkg::CFG_POOL_BASE;
		cfg_wdata <= base;
		@(negedge clk);
		cfg_addr  <= ffca_pkg::CFG_POOL_LENGTH;
		cfg_wdata <= {8'b0, len};
		@(negedge clk);
		cfg_we <= 1'b0;
		pool_base = base;
		pool_len = len;
		pool_reinit();
	endtask

	// random request built from the live picture of the pool
	task automatic random_batch(int count);
		int pick, j;
		bit [63:0] off, span;
		for (int n = 0; n < count; n++) begin
			while (pending_requests.size() > 1) @(negedge clk);
			pick = $urandom_range(99);
			j = (live_cnt > 0) ? $urandom_range(live_cnt - 1) : 0;
			if (pick < 45) begin
				span = $urandom_range(9) == 0 ? 64'($urandom_range(1, 8192)) :
					64'($urandom_range(1, 512));
				push_req(ffca_pkg::CMD_ALLOC, 48'({$urandom, $urandom}), span[39:0],
					$urandom_range(9) == 0 ? 6'($urandom) : 6'($urandom_range(8)));
			end else if (pick < 78) begin
				push_req(ffca_pkg::CMD_FREE,
					(live_cnt > 0 && pick < 72) ? live_start[j][47:0] :
					48'(pool_base + $urandom_range(4096)), 40'({$urandom, $urandom}),
					6'($urandom));
			end else if (pick < 92 && live_cnt > 0) begin
				off = $urandom_range(32'(live_len[j] - 1));
				span = live_len[j] - off + $urandom_range(2) - 1;
				push_req(ffca_pkg::CMD_FIND, 48'(live_start[j] + off), span[39:0],
					6'($urandom));
			end else begin
				push_req(ffca_pkg::cmd_e'($urandom_range(3)), 48'({$urandom, $urandom}),
					40'({$urandom, $urandom}), 6'($urandom));
			end
		end
	endtask

	initial begin
		pool_base = 0;
		pool_len = 0;
		pool_reinit();
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// phase 1: directed corners, no idling
		set_pool(48'h1000, 40'h10000);
		push_req(ffca_pkg::CMD_ALLOC, 48'h0, 40'h0, 6'd0);      // zero-byte allocate
		push_req(ffca_pkg::CMD_ALLOC, 48'hFFFF_FFFF_FFFF, 40'hFF_FFFF_FFFF, 6'd0);
		push_req(ffca_pkg::CMD_ALLOC, 48'h0, 40'h10, 6'd63);    // huge alignment
		push_req(ffca_pkg::CMD_ALLOC, 48'h0, 40'h100, 6'd0);    // lands at 0x1000
		push_req(ffca_pkg::CMD_ALLOC, 48'h0, 40'h100, 6'd9);    // front padding left free
		push_req(ffca_pkg::CMD_ALLOC, 48'h0, 40'h80, 6'd0);     // fits in the padding
		push_req(ffca_pkg::CMD_FIND, 48'h1000, 40'h100, 6'd0);  // exact span
		push_req(ffca_pkg::CMD_FIND, 48'h1080, 40'h80, 6'd0);   // ends at allocation end
		push_req(ffca_pkg::CMD_FIND, 48'h1080, 40'h81, 6'd0);   // runs past the end
		push_req(ffca_pkg::CMD_FIND, 48'h0, 40'h0, 6'd63);
		push_req(ffca_pkg::CMD_FREE, 48'h1234, 40'h0, 6'd0);    // unknown address
		push_req(ffca_pkg::CMD_FREE, 48'h1000, 40'h0, 6'd0);
		push_req(ffca_pkg::CMD_FREE, 48'h1000, 40'h0, 6'd0);    // double free
		push_req(ffca_pkg::CMD_NONE, 48'hFFFF_FFFF_FFFF, 40'hFF_FFFF_FFFF, 6'h3F);
		push_req(ffca_pkg::CMD_FREE, 48'h1100, 40'h0, 6'd0);    // merge with both sides
		push_req(ffca_pkg::CMD_ALLOC, 48'h0, 40'h10000, 6'd0);  // whole pool
		push_req(ffca_pkg::CMD_FREE, 48'h1000, 40'h0, 6'd0);
		for (int k = 0; k < 66; k++)                             // fill the allocation table
			push_req(ffca_pkg::CMD_ALLOC, 48'h0, 40'h1, 6'd3);
		random_batch(60);
		wait_drained();

		// phase 2: sender idles, receiver takes one long hold-off
		set_pool(48'h0, 40'h8000);
		send_idle_pct = 60;
		hold_req = 1'b1;
		random_batch(80);
		wait_drained();

		// phase 3: receiver stalls, pool clipped at the top of the address space
		set_pool(48'hFFFF_FFFF_0000, 40'hFF_FFFF_FFFF);
		send_idle_pct = 0;
		recv_stall_pct = 60;
		random_batch(80);
		wait_drained();

		// phase 4: both sides idle
		set_pool(48'($urandom) & 48'hFFFF_FFF0_0000, 40'h4000);
		send_idle_pct = 32;
		recv_stall_pct = 32;
		random_batch(80);
		wait_drained();

		// phase 5: empty pool at the highest base
		set_pool(48'hFFFF_FFFF_FFFF, 40'h0);
		send_idle_pct = 0;
		recv_stall_pct = 0;
		random_batch(30);
		wait_drained();

		$display("Covered %0d requests and %0d results over five pool settings,", n_requests,
			n_results);
		$display("statuses ok/nofit/unknown/overlap/notcov/full: %0d/%0d/%0d/%0d/%0d/%0d",
			status_seen[0], status_seen[1], status_seen[2], status_seen[3], status_seen[4],
			status_seen[5]);
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule

[sim.f]
rtl/core/ffca_pkg.sv
rtl/core/ffca_chunk_ram.sv
rtl/core/first_fit_coalescing_allocator.sv
dv/first_fit_coalescing_allocator_tb.sv
